// ===== sv/rrpi_pkg.sv =====
// Shared types and constants for the ray versus rotated rectangle block.
// No dependencies; every other file of the block but rrpi_chk imports this package.
package rrpi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int ROT_W         = 18;
    localparam int CFG_IDX_W     = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_HEIGHT = 3'd0,
        CFG_ROT_COS      = 3'd1,
        CFG_ROT_SIN      = 3'd2,
        CFG_BOUND_X_LOW  = 3'd3,
        CFG_BOUND_X_HIGH = 3'd4,
        CFG_BOUND_Z_LOW  = 3'd5,
        CFG_BOUND_Z_HIGH = 3'd6
    } t_cfg_idx;

    // One ray as it enters the block.
    typedef struct packed {
        logic signed [DATA_W-1:0] dir_z;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] start_z;
        logic signed [DATA_W-1:0] start_y;
        logic signed [DATA_W-1:0] start_x;
    } t_ray;

    // Status that travels alongside the point through the back stages.
    typedef struct packed {
        logic vld;
        logic zero;
        logic ovf;
    } t_ctl;

endpackage

// ===== sv/ray_rect_plane_intersect.sv =====
// Top level of the ray versus rotated horizontal rectangle test.
// Depends on rrpi_pkg, rrpi_div, rrpi_point and rrpi_rot.
//
// Usage:
//   Rays enter on the slave stream, one beat per ray; tdata packs start_x,
//   start_y, start_z, dir_x, dir_y, dir_z from bit 0 up. Results leave on the
//   master stream, one beat per ray in order; tdata packs hit_x, hit_y, hit_z
//   and ray_param, tuser carries hit (bit 0) and overflow (bit 1).
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while no
//   ray is in flight; indexes beyond the list are ignored.
// Timing:
//   The divider resolves one quotient bit per stage over 33 + FRAC_BITS stages,
//   behind an entry stage; six stages of saturate, multiply, add and compare
//   follow it.
//   Throughput is one ray per cycle while the receiver does not stall.
// Reset and stall:
//   Reset empties the pipeline and loads the register defaults.
//   When the receiver stalls with a result held, the whole pipeline freezes
//   and o_s_axis_tready drops until the output beat is taken; nothing is
//   lost or repeated.
module ray_rect_plane_intersect #(
    parameter int FRAC_BITS = rrpi_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // start_x, start_y, start_z, dir_x, dir_y, dir_z
    input  logic [191:0] i_s_axis_tdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // hit_x, hit_y, hit_z, ray_param
    output logic [127:0] o_m_axis_tdata,
    // hit, overflow
    output logic [1:0]   o_m_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import rrpi_pkg::*;

    localparam int NW = 33 + FRAC_BITS;

    // Configuration registers.
    logic signed [31:0]      r_plane_height;
    logic signed [ROT_W-1:0] r_rot_cos;
    logic signed [ROT_W-1:0] r_rot_sin;
    logic signed [31:0]      r_bound_x_low;
    logic signed [31:0]      r_bound_x_high;
    logic signed [31:0]      r_bound_z_low;
    logic signed [31:0]      r_bound_z_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_height <= '0;
            r_rot_cos      <= ROT_W'(64'sd1 <<< FRAC_BITS);
            r_rot_sin      <= '0;
            r_bound_x_low  <= '0;
            r_bound_x_high <= 32'(64'sd1 <<< FRAC_BITS);
            r_bound_z_low  <= '0;
            r_bound_z_high <= 32'(64'sd1 <<< FRAC_BITS);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PLANE_HEIGHT: r_plane_height <= i_cfg_data;
                CFG_ROT_COS:      r_rot_cos      <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_SIN:      r_rot_sin      <= i_cfg_data[ROT_W-1:0];
                CFG_BOUND_X_LOW:  r_bound_x_low  <= i_cfg_data;
                CFG_BOUND_X_HIGH: r_bound_x_high <= i_cfg_data;
                CFG_BOUND_Z_LOW:  r_bound_z_low  <= i_cfg_data;
                CFG_BOUND_Z_HIGH: r_bound_z_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or being drained.
    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    t_ray in_ray;
    assign in_ray = t_ray'(i_s_axis_tdata);

    logic            div_vld;
    t_ray            div_ray;
    logic [NW-1:0]   div_quo;
    logic            div_neg;
    logic            div_zero;

    rrpi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_vld          (i_s_axis_tvalid),
        .i_ray          (in_ray),
        .i_plane_height (r_plane_height),
        .o_vld          (div_vld),
        .o_ray          (div_ray),
        .o_quo          (div_quo),
        .o_neg          (div_neg),
        .o_zero         (div_zero)
    );

    t_ctl               pt_ctl;
    logic signed [31:0] pt_hx, pt_hy, pt_hz, pt_t;

    rrpi_point #(.FRAC_BITS(FRAC_BITS)) u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (div_vld),
        .i_ray   (div_ray),
        .i_quo   (div_quo),
        .i_neg   (div_neg),
        .i_zero  (div_zero),
        .o_ctl   (pt_ctl),
        .o_hx    (pt_hx),
        .o_hy    (pt_hy),
        .o_hz    (pt_hz),
        .o_t     (pt_t)
    );

    logic               out_hit, out_ovf;
    logic signed [31:0] out_hx, out_hy, out_hz, out_t;

    rrpi_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_ctl          (pt_ctl),
        .i_hx           (pt_hx),
        .i_hy           (pt_hy),
        .i_hz           (pt_hz),
        .i_t            (pt_t),
        .i_rot_cos      (r_rot_cos),
        .i_rot_sin      (r_rot_sin),
        .i_bound_x_low  (r_bound_x_low),
        .i_bound_x_high (r_bound_x_high),
        .i_bound_z_low  (r_bound_z_low),
        .i_bound_z_high (r_bound_z_high),
        .o_vld          (o_m_axis_tvalid),
        .o_hit          (out_hit),
        .o_ovf          (out_ovf),
        .o_hx           (out_hx),
        .o_hy           (out_hy),
        .o_hz           (out_hz),
        .o_t            (out_t)
    );

    assign o_m_axis_tdata = {out_t, out_hz, out_hy, out_hx};
    assign o_m_axis_tuser = {out_ovf, out_hit};

endmodule

// ===== sv/rrpi_div.sv =====
// Pipelined restoring divider for t = ((plane_height - start_y) << FRAC_BITS) / dir_y.
// One quotient bit per stage on magnitudes. Depends on rrpi_pkg.
module rrpi_div #(
    parameter int FRAC_BITS = rrpi_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  rrpi_pkg::t_ray      i_ray,
    input  logic signed [31:0]  i_plane_height,
    output logic                o_vld,
    output rrpi_pkg::t_ray      o_ray,
    output logic [33+FRAC_BITS-1:0] o_quo,
    output logic                o_neg,
    output logic                o_zero
);
    import rrpi_pkg::*;

    localparam int NW = 33 + FRAC_BITS;
    localparam int AW = DATA_W + NW;

    logic          r_vld  [0:NW];
    logic [AW-1:0] r_acc  [0:NW];
    logic [31:0]   r_den  [0:NW];
    t_ray          r_ray  [0:NW];
    logic          r_neg  [0:NW];
    logic          r_zero [0:NW];

    logic signed [32:0] diff;
    logic [32:0]        num_mag;
    logic [31:0]        den_mag;

    // Entry: signed numerator and divisor split into sign and magnitude.
    always_comb begin
        diff    = {i_plane_height[31], i_plane_height} - {i_ray.start_y[31], i_ray.start_y};
        num_mag = diff[32] ? 33'(-diff) : 33'(diff);
        den_mag = i_ray.dir_y[31] ? 32'(-i_ray.dir_y) : 32'(i_ray.dir_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0]  <= {{DATA_W{1'b0}}, num_mag, {FRAC_BITS{1'b0}}};
            r_den[0]  <= den_mag;
            r_ray[0]  <= i_ray;
            r_neg[0]  <= diff[32] ^ i_ray.dir_y[31];
            r_zero[0] <= (i_ray.dir_y == '0);
        end
    end

    // One quotient bit per stage: shift, trial subtract, keep or restore.
    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [32:0]   trial;
        logic          ge;
        logic [32:0]   rem;
        logic [AW-1:0] n_acc;

        always_comb begin
            trial = r_acc[k][AW-1:NW-1];
            ge    = (trial >= {1'b0, r_den[k]});
            rem   = ge ? (trial - {1'b0, r_den[k]}) : trial;
            n_acc = {rem[31:0], r_acc[k][NW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k+1]  <= n_acc;
                r_den[k+1]  <= r_den[k];
                r_ray[k+1]  <= r_ray[k];
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    assign o_vld  = r_vld[NW];
    assign o_ray  = r_ray[NW];
    assign o_quo  = r_acc[NW][NW-1:0];
    assign o_neg  = r_neg[NW];
    assign o_zero = r_zero[NW];

endmodule

// ===== sv/rrpi_point.sv =====
// Saturates t, multiplies it by the direction and adds the origin to get the point.
// Three register stages. Depends on rrpi_pkg.
module rrpi_point #(
    parameter int FRAC_BITS = rrpi_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  rrpi_pkg::t_ray       i_ray,
    input  logic [33+FRAC_BITS-1:0] i_quo,
    input  logic                 i_neg,
    input  logic                 i_zero,
    output rrpi_pkg::t_ctl       o_ctl,
    output logic signed [31:0]   o_hx,
    output logic signed [31:0]   o_hy,
    output logic signed [31:0]   o_hz,
    output logic signed [31:0]   o_t
);
    import rrpi_pkg::*;

    localparam int NW = 33 + FRAC_BITS;
    localparam logic [31:0] S_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S_MIN = 32'h8000_0000;

    // Stage A: signed t with saturation.
    logic        big;
    logic        a_ovf;
    logic [31:0] a_t;
    t_ctl        r_a_ctl;
    logic signed [31:0] r_a_t;
    t_ray        r_a_ray;

    always_comb begin
        big = |i_quo[NW-1:32];
        if (i_neg) begin
            a_ovf = big || (i_quo[31] && (|i_quo[30:0]));
            a_t   = a_ovf ? S_MIN : 32'(-i_quo[31:0]);
        end else begin
            a_ovf = big || i_quo[31];
            a_t   = a_ovf ? S_MAX : i_quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_a_ctl.vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctl.zero <= i_zero;
            r_a_ctl.ovf  <= a_ovf;
            r_a_t        <= a_t;
            r_a_ray      <= i_ray;
        end
    end

    // Stage B: t times each direction component.
    t_ctl               r_b_ctl;
    logic signed [31:0] r_b_t;
    logic signed [31:0] r_b_sx, r_b_sy, r_b_sz;
    logic signed [63:0] r_b_px, r_b_py, r_b_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_b_ctl.vld <= r_a_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_ctl.zero <= r_a_ctl.zero;
            r_b_ctl.ovf  <= r_a_ctl.ovf;
            r_b_t        <= r_a_t;
            r_b_sx       <= r_a_ray.start_x;
            r_b_sy       <= r_a_ray.start_y;
            r_b_sz       <= r_a_ray.start_z;
            r_b_px       <= r_a_t * r_a_ray.dir_x;
            r_b_py       <= r_a_t * r_a_ray.dir_y;
            r_b_pz       <= r_a_t * r_a_ray.dir_z;
        end
    end

    // Stage C: origin plus floored product, saturated to 32 bits.
    function automatic logic [32:0] sat_add(input logic signed [31:0] s,
                                            input logic signed [63:0] p);
        logic signed [63:0] sh;
        logic signed [64:0] sum;
        logic               o;
        logic [31:0]        v;
        sh  = p >>> FRAC_BITS;
        sum = {{33{s[31]}}, s} + {sh[63], sh};
        o   = (sum[64:31] != {34{1'b0}}) && (sum[64:31] != {34{1'b1}});
        v   = o ? (sum[64] ? S_MIN : S_MAX) : sum[31:0];
        return {o, v};
    endfunction

    logic [32:0] c_x, c_y, c_z;

    always_comb begin
        c_x = sat_add(r_b_sx, r_b_px);
        c_y = sat_add(r_b_sy, r_b_py);
        c_z = sat_add(r_b_sz, r_b_pz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl.vld <= r_b_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl.zero <= r_b_ctl.zero;
            o_ctl.ovf  <= r_b_ctl.ovf | c_x[32] | c_y[32] | c_z[32];
            o_hx       <= c_x[31:0];
            o_hy       <= c_y[31:0];
            o_hz       <= c_z[31:0];
            o_t        <= r_b_t;
        end
    end

endmodule

// ===== sv/rrpi_rot.sv =====
// Rotates the hit point into the rectangle frame and tests the open bounds.
// Three register stages, the last one is the block's output register. Depends on rrpi_pkg.
module rrpi_rot #(
    parameter int FRAC_BITS = rrpi_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  rrpi_pkg::t_ctl     i_ctl,
    input  logic signed [31:0] i_hx,
    input  logic signed [31:0] i_hy,
    input  logic signed [31:0] i_hz,
    input  logic signed [31:0] i_t,
    input  logic signed [17:0] i_rot_cos,
    input  logic signed [17:0] i_rot_sin,
    input  logic signed [31:0] i_bound_x_low,
    input  logic signed [31:0] i_bound_x_high,
    input  logic signed [31:0] i_bound_z_low,
    input  logic signed [31:0] i_bound_z_high,
    output logic               o_vld,
    output logic               o_hit,
    output logic               o_ovf,
    output logic signed [31:0] o_hx,
    output logic signed [31:0] o_hy,
    output logic signed [31:0] o_hz,
    output logic signed [31:0] o_t
);
    import rrpi_pkg::*;

    localparam int PW = ROT_W + DATA_W;
    localparam int SW = PW + 1;
    localparam int CW = ((33 + FRAC_BITS) > SW) ? (34 + FRAC_BITS) : (SW + 1);

    // Stage D: the four rotation products.
    t_ctl               r_d_ctl;
    logic signed [31:0] r_d_hx, r_d_hy, r_d_hz, r_d_t;
    logic signed [PW-1:0] r_d_cx, r_d_sz, r_d_sx, r_d_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_d_ctl.vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_ctl.zero <= i_ctl.zero;
            r_d_ctl.ovf  <= i_ctl.ovf;
            r_d_hx       <= i_hx;
            r_d_hy       <= i_hy;
            r_d_hz       <= i_hz;
            r_d_t        <= i_t;
            r_d_cx       <= i_rot_cos * i_hx;
            r_d_sz       <= i_rot_sin * i_hz;
            r_d_sx       <= i_rot_sin * i_hx;
            r_d_cz       <= i_rot_cos * i_hz;
        end
    end

    // Stage E: rotated coordinates, exact.
    t_ctl               r_e_ctl;
    logic signed [31:0] r_e_hx, r_e_hy, r_e_hz, r_e_t;
    logic signed [SW-1:0] r_e_xr, r_e_zr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_e_ctl.vld <= r_d_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_ctl.zero <= r_d_ctl.zero;
            r_e_ctl.ovf  <= r_d_ctl.ovf;
            r_e_hx       <= r_d_hx;
            r_e_hy       <= r_d_hy;
            r_e_hz       <= r_d_hz;
            r_e_t        <= r_d_t;
            r_e_xr       <= {r_d_cx[PW-1], r_d_cx} - {r_d_sz[PW-1], r_d_sz};
            r_e_zr       <= {r_d_sx[PW-1], r_d_sx} + {r_d_cz[PW-1], r_d_cz};
        end
    end

    // Stage F: strict bound compares against the scaled bounds.
    function automatic logic signed [CW-1:0] scale(input logic signed [31:0] b);
        return {{(CW-32-FRAC_BITS){b[31]}}, b, {FRAC_BITS{1'b0}}};
    endfunction

    logic signed [CW-1:0] xr_w, zr_w;
    logic                 in_box;

    always_comb begin
        xr_w   = {{(CW-SW){r_e_xr[SW-1]}}, r_e_xr};
        zr_w   = {{(CW-SW){r_e_zr[SW-1]}}, r_e_zr};
        in_box = (xr_w > scale(i_bound_x_low)) && (xr_w < scale(i_bound_x_high)) &&
                 (zr_w > scale(i_bound_z_low)) && (zr_w < scale(i_bound_z_high));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_e_ctl.vld;
        end
    end

    // A ray parallel to the plane reports all zeros.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_e_ctl.zero) begin
                o_hit <= 1'b0;
                o_ovf <= 1'b0;
                o_hx  <= '0;
                o_hy  <= '0;
                o_hz  <= '0;
                o_t   <= '0;
            end else begin
                o_hit <= in_box && !r_e_ctl.ovf;
                o_ovf <= r_e_ctl.ovf;
                o_hx  <= r_e_hx;
                o_hy  <= r_e_hy;
                o_hz  <= r_e_hz;
                o_t   <= r_e_t;
            end
        end
    end

endmodule

// ===== sv/rrpi_chk.sv =====
// Port-level checks for ray_rect_plane_intersect, attached by the bind below.
// Depends only on the top level's port list.
module rrpi_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic [127:0] o_m_axis_tdata,
    input logic [1:0]   o_m_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready
);

    // A held result beat stays valid while the receiver stalls.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped during stall");

    // A held result beat keeps its payload while the receiver stalls.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) &&
        $stable(o_m_axis_tuser))
        else $error("result beat changed during stall");

    // A saturated result never reports a hit.
    a_hit_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("hit reported together with overflow");

    // Input side is ready exactly when the output register can move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output drain");

endmodule

bind ray_rect_plane_intersect rrpi_chk u_rrpi_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);
